/* hw/rtl/apr_pkg.sv */
// Shared types and constants for the aging page replacement block.
// Used by apr_mod and aging_page_replacement; depends on nothing.
package apr_pkg;

   // Default sizes
   localparam int NUM_FRAMES_DEF = 64;
   localparam int AGE_BITS_DEF   = 16;

   // Field widths
   localparam int TIME_W       = 32;
   localparam int VADDR_W      = 32;
   localparam int FRAME_W      = 6;
   localparam int PERIOD_W     = 16;
   localparam int FIU_W        = 7;
   localparam int VICTIM_AGE_W = 16;
   localparam int REQ_TYPE_W   = 2;

   // Stream and register port widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - (VADDR_W + FRAME_W + VICTIM_AGE_W);
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   // Request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_ACCESS  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_INSTALL = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY   = 2'd2;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIU    = 1'b1;

   // Register reset values
   localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd10;
   localparam logic [FIU_W-1:0]    FIU_RST    = 7'd64;

   // Status from the remainder unit
   typedef struct packed {
      logic done;     // one-cycle pulse when the remainder is ready
      logic is_zero;  // remainder is zero, valid with done
   } apr_div_type;

endpackage

/* hw/rtl/apr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module apr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hw/rtl/apr_mod.sv */
// Bit-serial remainder unit: time count modulo aging period, one bit a cycle.
// Depends on apr_pkg for widths and the status struct.
module apr_mod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [apr_pkg::TIME_W-1:0]      dividend,
   input  logic [apr_pkg::PERIOD_W-1:0]    divisor,   // never zero
   output apr_pkg::apr_div_type            status
);

   import apr_pkg::*;

   localparam int STEP_W = $clog2(TIME_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [TIME_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [PERIOD_W-1:0] div_ff, div_in;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W:0]   diff;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[TIME_W-1]};
      diff    = shifted - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[TIME_W-2:0], 1'b0};
         rem_in  = (shifted >= {1'b0, div_ff}) ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.done    = done_ff;
   assign status.is_zero = (rem_ff == '0);

endmodule

/* hw/rtl/aging_page_replacement.sv */
// Aging page replacement over NUM_FRAMES frames: install, access and victim query.
// Depends on apr_pkg, apr_ram (age, last-use and page stores) and apr_mod.
//
// One request item is handled at a time and req_tready is high only while the
// block is idle. After reset a clearing pass writes zero to every frame entry
// before the first item is taken. An access starts the bit-serial remainder
// unit that checks the time count against the aging period (one bit a cycle
// over the 32-bit count); when the count hits a multiple of the period it then
// reads, shifts and writes back the age of each in-use frame through the age
// store's single port pair. A victim query reads one frame a cycle and
// compares it in a single shared comparator, then the result is loaded into
// the output register, waiting there while an earlier victim is still held.
// The result register lets the next item be taken while a victim still waits
// on rsp_.
module aging_page_replacement #(
   parameter int NUM_FRAMES = apr_pkg::NUM_FRAMES_DEF,
   parameter int AGE_BITS   = apr_pkg::AGE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [apr_pkg::REQ_DATA_W-1:0]    req_tdata,  // [5:0] frame, [37:6] vaddr, pad
   input  logic [apr_pkg::REQ_TYPE_W-1:0]    req_tuser,  // [1:0] req_type
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [apr_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [31:0] victim_vaddr,
                                                         // [37:32] victim_frame,
                                                         // [53:38] victim_age, pad
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [apr_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [apr_pkg::CSR_DATA_W-1:0]    csr_data
);

   import apr_pkg::*;

   localparam int IDX_W  = $clog2(NUM_FRAMES);
   localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
   localparam int CMP_W  = (CNT_W > FIU_W) ? CNT_W : FIU_W;
   localparam int AEXT_W = (AGE_BITS > VICTIM_AGE_W) ? AGE_BITS : VICTIM_AGE_W;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DIVIDE, ST_AGE, ST_SCAN, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [FIU_W-1:0]     fiu_ff, fiu_in;
   logic [NUM_FRAMES-1:0] mark_ff, mark_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic [TIME_W-1:0]    best_lu_ff, best_lu_in;
   logic [VADDR_W-1:0]   best_page_ff, best_page_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic [REQ_TYPE_W-1:0] req_type;
   logic [FRAME_W-1:0]    req_frame;
   logic [VADDR_W-1:0]    req_vaddr;

   // derived control
   logic [CMP_W-1:0]     fiu_ext, n_cmp, frame_ext, cnt_ext, best_ext;
   logic [IDX_W-1:0]     f_idx;
   logic                 in_range, issue, take;
   logic [AGE_BITS-1:0]  aged;
   logic [AEXT_W-1:0]    age_ext;

   // store ports
   logic                 age_we, lu_we, pg_we, rd_en;
   logic [IDX_W-1:0]     age_waddr, lu_waddr, pg_waddr, rd_addr;
   logic [AGE_BITS-1:0]  age_wdata, age_rdata;
   logic [TIME_W-1:0]    lu_wdata, lu_rdata;
   logic [VADDR_W-1:0]   pg_wdata, pg_rdata;

   // remainder unit
   logic                 div_start;
   logic [PERIOD_W-1:0]  div_divisor;
   apr_div_type          div_st;

   assign req_type  = req_tuser;
   assign req_frame = req_tdata[FRAME_W-1:0];
   assign req_vaddr = req_tdata[FRAME_W +: VADDR_W];

   // effective in-use count: zero acts as one, clamped to the store depth
   always_comb begin
      fiu_ext = CMP_W'(fiu_ff);
      if (fiu_ext == '0) begin
         n_cmp = CMP_W'(1);
      end else if (fiu_ext > CMP_W'(NUM_FRAMES)) begin
         n_cmp = CMP_W'(NUM_FRAMES);
      end else begin
         n_cmp = fiu_ext;
      end
   end

   assign frame_ext   = CMP_W'(req_frame);
   assign f_idx       = frame_ext[IDX_W-1:0];
   assign in_range    = (frame_ext < n_cmp);
   assign cnt_ext     = CMP_W'(cnt_ff);
   assign best_ext    = CMP_W'(best_idx_ff);
   assign issue       = ((state_ff == ST_SCAN) || (state_ff == ST_AGE)) && (cnt_ext < n_cmp);
   assign rd_addr     = cnt_ff[IDX_W-1:0];
   assign rd_en       = issue;
   assign div_divisor = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   // shared comparator: smaller age wins, then older last use, then lower index
   assign take = (pend_idx_ff == '0) || (age_rdata < best_age_ff) ||
                 ((age_rdata == best_age_ff) && (lu_rdata < best_lu_ff));

   // one aging step on the frame read last cycle
   assign aged    = {mark_ff[pend_idx_ff], age_rdata[AGE_BITS-1:1]};
   assign age_ext = AEXT_W'(best_age_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = issue;
      pend_idx_in  = cnt_ff[IDX_W-1:0];
      time_in      = time_ff;
      period_in    = period_ff;
      fiu_in       = fiu_ff;
      mark_in      = mark_ff;
      best_idx_in  = best_idx_ff;
      best_age_in  = best_age_ff;
      best_lu_in   = best_lu_ff;
      best_page_in = best_page_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      age_we       = 1'b0;
      age_waddr    = f_idx;
      age_wdata    = '0;
      lu_we        = 1'b0;
      lu_waddr     = f_idx;
      lu_wdata     = time_ff;
      pg_we        = 1'b0;
      pg_waddr     = f_idx;
      pg_wdata     = req_vaddr;
      div_start    = 1'b0;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PERIOD: period_in = csr_data;
            CSR_FIU:    fiu_in    = csr_data[FIU_W-1:0];
            default:    ;
         endcase
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            age_we    = 1'b1;
            age_waddr = cnt_ff[IDX_W-1:0];
            lu_we     = 1'b1;
            lu_waddr  = cnt_ff[IDX_W-1:0];
            lu_wdata  = '0;
            pg_we     = 1'b1;
            pg_waddr  = cnt_ff[IDX_W-1:0];
            pg_wdata  = '0;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_FRAMES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_type)
                  REQ_ACCESS: begin
                     if (in_range) begin
                        lu_we          = 1'b1;
                        mark_in[f_idx] = 1'b1;
                        time_in        = time_ff + TIME_W'(1);
                        div_start      = 1'b1;
                        state_in       = ST_DIVIDE;
                     end
                  end
                  REQ_INSTALL: begin
                     if (in_range) begin
                        age_we         = 1'b1;
                        lu_we          = 1'b1;
                        pg_we          = 1'b1;
                        mark_in[f_idx] = 1'b0;
                     end
                  end
                  REQ_QUERY: begin
                     cnt_in   = '0;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_st.done) begin
               cnt_in   = '0;
               state_in = div_st.is_zero ? ST_AGE : ST_IDLE;
            end
         end
         ST_AGE: begin
            if (pend_ff) begin
               age_we    = 1'b1;
               age_waddr = pend_idx_ff;
               age_wdata = aged;
            end
            if (!issue && !pend_ff) begin
               mark_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (pend_ff && take) begin
               best_idx_in  = pend_idx_ff;
               best_age_in  = age_rdata;
               best_lu_in   = lu_rdata;
               best_page_in = pg_rdata;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, age_ext[VICTIM_AGE_W-1:0],
                               best_ext[FRAME_W-1:0], best_page_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         time_ff      <= '0;
         period_ff    <= PERIOD_RST;
         fiu_ff       <= FIU_RST;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         time_ff      <= time_in;
         period_ff    <= period_in;
         fiu_ff       <= fiu_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_age_ff  <= best_age_in;
      best_lu_ff   <= best_lu_in;
      best_page_ff <= best_page_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // frame stores
   apr_ram #(.WIDTH(AGE_BITS), .DEPTH(NUM_FRAMES)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (age_rdata)
   );

   apr_ram #(.WIDTH(TIME_W), .DEPTH(NUM_FRAMES)) u_lu_ram (
      .clock   (clock),
      .wr_en   (lu_we),
      .wr_addr (lu_waddr),
      .wr_data (lu_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (lu_rdata)
   );

   apr_ram #(.WIDTH(VADDR_W), .DEPTH(NUM_FRAMES)) u_pg_ram (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (pg_waddr),
      .wr_data (pg_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (pg_rdata)
   );

   // time count modulo aging period
   apr_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (time_in),
      .divisor  (div_divisor),
      .status   (div_st)
   );

`ifndef ASSERT_OFF
   // a query item always starts the scan
   a_query_scans: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_type == REQ_QUERY)) |=> (state_ff == ST_SCAN))
      else $error("query did not start a scan");

   // the read pipeline only runs during a sweep
   a_pend_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_AGE)))
      else $error("read pending outside a sweep");

   // the chosen victim lies inside the in-use set
   a_victim_in_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (best_ext < n_cmp))
      else $error("victim outside in-use frames");

   // a waiting result is never overwritten by the next victim
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");
`endif

endmodule
